/* rtl/ipc_pkg.sv */
// shared types, constants and character decode for the infix to postfix converter
`timescale 1ns / 1ps
package ipc_pkg;

  // stack sizing and per-item result limit
  localparam int STACK_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 32;
  localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);

  // character constants
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_TIMES = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  // stacked operator codes
  typedef enum logic [2:0] {
    OP_LPAR  = 3'd0,
    OP_PLUS  = 3'd1,
    OP_MINUS = 3'd2,
    OP_TIMES = 3'd3,
    OP_DIV   = 3'd4
  } op_code_t;

  // input character classes
  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_LETTER,
    CLS_LPAR,
    CLS_RPAR,
    CLS_OP
  } char_cls_t;

  // output beat source select
  typedef enum logic [1:0] {
    SEL_CHAR,
    SEL_TOP,
    SEL_SPACE,
    SEL_ERR
  } emit_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic      accept;
    logic      emit;
    emit_sel_t emit_sel;
    logic      emit_last;
    logic      pop;
    logic      push;
  } ipc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    char_cls_t in_cls;
    logic      in_flush;
    logic      emit_ok;
    logic      count_zero;
    logic      count_full;
    logic      top_is_lpar;
    logic      op_cnt_zero;
    logic      prec_pops;
  } ipc_stat_t;

  function automatic char_cls_t char_class(input logic [7:0] ch);
    char_cls_t cls;
    cls = CLS_OTHER;
    if ((ch >= CH_LO_A && ch <= CH_LO_Z) || (ch >= CH_UP_A && ch <= CH_UP_Z)) begin
      cls = CLS_LETTER;
    end else if (ch == CH_LPAR) begin
      cls = CLS_LPAR;
    end else if (ch == CH_RPAR) begin
      cls = CLS_RPAR;
    end else if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_TIMES || ch == CH_DIV) begin
      cls = CLS_OP;
    end
    return cls;
  endfunction

  function automatic op_code_t char_code(input logic [7:0] ch);
    op_code_t code;
    case (ch)
      CH_PLUS:  code = OP_PLUS;
      CH_MINUS: code = OP_MINUS;
      CH_TIMES: code = OP_TIMES;
      CH_DIV:   code = OP_DIV;
      default:  code = OP_LPAR;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] code_char(input op_code_t code);
    logic [7:0] ch;
    case (code)
      OP_LPAR:  ch = CH_LPAR;
      OP_PLUS:  ch = CH_PLUS;
      OP_MINUS: ch = CH_MINUS;
      OP_TIMES: ch = CH_TIMES;
      OP_DIV:   ch = CH_DIV;
      default:  ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic [1:0] code_prec(input op_code_t code);
    logic [1:0] p;
    case (code)
      OP_PLUS, OP_MINUS: p = 2'd1;
      OP_TIMES, OP_DIV:  p = 2'd2;
      default:           p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

/* rtl/ipc_dpath.sv */
// datapath: input latch, operator stack, result counter and output register
`timescale 1ns / 1ps
module ipc_dpath #(
  parameter int STACK_DEPTH = ipc_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tuser,   // action
  input  logic [7:0]        s_tdata,   // char_in
  input  ipc_pkg::ipc_cmd_t cmd,
  output ipc_pkg::ipc_stat_t stat,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // out_char
  output logic              m_tuser,   // error
  output logic              m_tlast    // last
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);

  ipc_pkg::op_code_t op_stack [STACK_DEPTH];
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  op_cnt;
  logic [CNT_W-1:0]  count_m1;
  logic [ipc_pkg::RES_CNT_W-1:0] res_cnt;
  logic [7:0]        cur_char;
  ipc_pkg::op_code_t cur_code;
  ipc_pkg::op_code_t top_code;
  logic              slot_free;
  logic              trunc;
  logic              load;
  logic [7:0]        beat_char;

  // top of stack read
  assign count_m1 = count - CNT_W'(1);
  assign top_code = op_stack[count_m1[IDX_W-1:0]];

  // result slot and truncation
  assign slot_free = !m_tvalid || m_tready;
  assign trunc     = (res_cnt == ipc_pkg::RES_CNT_W'(ipc_pkg::MAX_RESULTS));
  assign load      = cmd.emit && !trunc && slot_free;

  // status toward the controller
  always_comb begin
    stat.in_cls      = ipc_pkg::char_class(s_tdata);
    stat.in_flush    = s_tuser;
    stat.emit_ok     = trunc || slot_free;
    stat.count_zero  = (count == '0);
    stat.count_full  = (count == CNT_W'(STACK_DEPTH));
    stat.top_is_lpar = (top_code == ipc_pkg::OP_LPAR);
    stat.op_cnt_zero = (op_cnt == '0);
    stat.prec_pops   = (ipc_pkg::code_prec(cur_code) <= ipc_pkg::code_prec(top_code));
  end

  // beat character select
  always_comb begin
    case (cmd.emit_sel)
      ipc_pkg::SEL_CHAR:  beat_char = cur_char;
      ipc_pkg::SEL_TOP:   beat_char = ipc_pkg::code_char(top_code);
      ipc_pkg::SEL_SPACE: beat_char = ipc_pkg::CH_SPACE;
      default:            beat_char = ipc_pkg::CH_NUL;
    endcase
  end

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_char <= s_tdata;
      cur_code <= ipc_pkg::char_code(s_tdata);
    end
  end

  // stack storage
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      op_stack[count[IDX_W-1:0]] <= cur_code;
    end
  end

  // stack depth and operator count
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      op_cnt <= '0;
    end else if (cmd.push) begin
      count <= count + CNT_W'(1);
      if (cur_code != ipc_pkg::OP_LPAR) begin
        op_cnt <= op_cnt + CNT_W'(1);
      end
    end else if (cmd.pop) begin
      count <= count_m1;
      if (top_code != ipc_pkg::OP_LPAR) begin
        op_cnt <= op_cnt - CNT_W'(1);
      end
    end
  end

  // results sent for the current item
  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= '0;
    end else if (cmd.accept) begin
      res_cnt <= '0;
    end else if (load) begin
      res_cnt <= res_cnt + ipc_pkg::RES_CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= beat_char;
      m_tuser <= (cmd.emit_sel == ipc_pkg::SEL_ERR);
      m_tlast <= cmd.emit_last ||
                 (res_cnt == ipc_pkg::RES_CNT_W'(ipc_pkg::MAX_RESULTS - 1));
    end
  end

endmodule

/* rtl/ipc_ctrl.sv */
// controller: sequences letters, pops, pushes and flushes one beat at a time
`timescale 1ns / 1ps
module ipc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  ipc_pkg::ipc_stat_t stat,
  output ipc_pkg::ipc_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHAR,
    ST_SPACE,
    ST_LOOP,
    ST_PUSH
  } state_t;

  typedef enum logic [1:0] {
    K_LETTER,
    K_CLOSE,
    K_OPER,
    K_FLUSH
  } kind_t;

  state_t state, state_next;
  kind_t  kind, kind_next;
  logic   go;
  logic   more_pops;

  assign go = stat.emit_ok;

  // whether the current loop keeps emitting operators
  always_comb begin
    case (kind)
      K_CLOSE: more_pops = !stat.count_zero && !stat.top_is_lpar;
      K_OPER:  more_pops = !stat.count_zero && stat.prec_pops;
      K_FLUSH: more_pops = !stat.op_cnt_zero;
      default: more_pops = 1'b0;
    endcase
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    kind_next     = kind;
    s_tready      = (state == ST_IDLE);
    cmd           = '0;
    cmd.emit_sel  = ipc_pkg::SEL_CHAR;
    case (state)
      ST_IDLE: begin
        cmd.accept = s_tvalid;
        if (s_tvalid) begin
          if (stat.in_flush) begin
            kind_next  = K_FLUSH;
            state_next = ST_LOOP;
          end else begin
            case (stat.in_cls)
              ipc_pkg::CLS_LETTER: begin
                kind_next  = K_LETTER;
                state_next = ST_CHAR;
              end
              ipc_pkg::CLS_LPAR: begin
                state_next = ST_PUSH;
              end
              ipc_pkg::CLS_RPAR: begin
                kind_next  = K_CLOSE;
                state_next = ST_LOOP;
              end
              ipc_pkg::CLS_OP: begin
                kind_next  = K_OPER;
                state_next = ST_LOOP;
              end
              default: begin
                state_next = ST_IDLE;
              end
            endcase
          end
        end
      end
      ST_CHAR: begin
        cmd.emit     = 1'b1;
        cmd.emit_sel = ipc_pkg::SEL_CHAR;
        if (go) begin
          state_next = ST_SPACE;
        end
      end
      ST_SPACE: begin
        // stack already popped, so the check looks at the new top
        cmd.emit      = 1'b1;
        cmd.emit_sel  = ipc_pkg::SEL_SPACE;
        cmd.emit_last = !more_pops;
        if (go) begin
          state_next = (kind == K_LETTER) ? ST_IDLE : ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (stat.count_zero) begin
          state_next = (kind == K_OPER) ? ST_PUSH : ST_IDLE;
        end else if (stat.top_is_lpar) begin
          // open paren: dropped by a flush or a close, stops an operator
          if (kind == K_OPER) begin
            state_next = ST_PUSH;
          end else begin
            cmd.pop = 1'b1;
            if (kind == K_CLOSE) begin
              state_next = ST_IDLE;
            end
          end
        end else if (kind == K_OPER && !stat.prec_pops) begin
          state_next = ST_PUSH;
        end else begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = ipc_pkg::SEL_TOP;
          cmd.pop      = go;
          if (go) begin
            state_next = ST_SPACE;
          end
        end
      end
      ST_PUSH: begin
        if (stat.count_full) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = ipc_pkg::SEL_ERR;
          cmd.emit_last = 1'b1;
          if (go) begin
            state_next = ST_IDLE;
          end
        end else begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      kind  <= K_LETTER;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

endmodule

/* rtl/infix_to_postfix_converter.sv */
// Infix to postfix converter top level: controller plus stack datapath.
// A letter emits its character and a space, a '(' is pushed, an operator emits
// and pops each stacked operator of no lower precedence and is then pushed, a ')'
// emits and pops operators down to its '(' and drops it, and a flush emits every
// operator and drops each '('; output stalls hold the sequence. One item at a time,
// at most one output beat per cycle; each letter and popped operator moves two beats.
// Reset (rst, synchronous): stack empty, output register empty, controller idle.
`timescale 1ns / 1ps
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = ipc_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // char_in
  input  logic       s_tuser,   // action
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_char
  output logic       m_tuser,   // error
  output logic       m_tlast    // last
);

  ipc_pkg::ipc_cmd_t  cmd;
  ipc_pkg::ipc_stat_t stat;

  // sequencer
  ipc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // stack and output datapath
  ipc_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // error beat carries a zero character and ends its item
  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata == 8'h00) && m_tlast)
    else $error("error beat with data or without last");

  // no pop from an empty stack
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !stat.count_zero)
    else $error("pop on empty stack");

  // no push onto a full stack
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !stat.count_full)
    else $error("push on full stack");

  // stack is only touched while an item is in work
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !cmd.pop && !cmd.push && !cmd.emit)
    else $error("stack or output activity while idle");

endmodule
